// ----- rtl/bpb_pkg.sv -----
`timescale 1ns / 1ps

package bpb_pkg;

  localparam int VALUE_W = 32;
  localparam int CFG_W = 3;
  localparam int BCD_W = 40;
  localparam int MAX_BYTES_DEF = 5;
  localparam logic [CFG_W-1:0] DIGIT_BYTES_RST = 3'd5;

  typedef struct packed {
    logic             valid;
    logic             sticky;
    logic [CFG_W-1:0] bytes;
  } ctl_t;

endpackage

// ----- rtl/bpb_cell.sv -----
`timescale 1ns / 1ps

module bpb_cell #(
  parameter int NDIG = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bpb_pkg::ctl_t                ctl_in,
  input  logic [bpb_pkg::VALUE_W-1:0]  rest_in,
  input  logic [4*NDIG-1:0]            digits_in,
  output bpb_pkg::ctl_t                ctl_out,
  output logic [bpb_pkg::VALUE_W-1:0]  rest_out,
  output logic [4*NDIG-1:0]            digits_out
);

  logic [4*NDIG-1:0] adj;
  logic [4*NDIG:0]   shifted;

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      if (digits_in[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = digits_in[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = digits_in[4*k +: 4];
      end
    end
    shifted = {adj, rest_in[bpb_pkg::VALUE_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.sticky <= ctl_in.sticky | shifted[4*NDIG];
    ctl_out.bytes  <= ctl_in.bytes;
    rest_out       <= {rest_in[bpb_pkg::VALUE_W-2:0], 1'b0};
    digits_out     <= shifted[4*NDIG-1:0];
  end

endmodule

// ----- rtl/bpb_out.sv -----
`timescale 1ns / 1ps

module bpb_out #(
  parameter int MAX_BYTES = bpb_pkg::MAX_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bpb_pkg::ctl_t               ctl_in,
  input  logic [8*MAX_BYTES-1:0]      digits_in,
  output logic                        done,
  output logic [bpb_pkg::BCD_W-1:0]   bcd_digits,
  output logic                        overflow
);

  localparam int NDIG = 2 * MAX_BYTES;
  localparam logic [bpb_pkg::CFG_W-1:0] MAX_B = bpb_pkg::CFG_W'(MAX_BYTES);

  logic [bpb_pkg::CFG_W-1:0] eff;
  logic [bpb_pkg::CFG_W:0]   keep;
  logic [bpb_pkg::BCD_W-1:0] bcd_next;
  logic                      overflow_next;

  always_comb begin
    eff = (ctl_in.bytes > MAX_B) ? MAX_B : ctl_in.bytes;
    keep = {eff, 1'b0};
    bcd_next = '0;
    overflow_next = ctl_in.sticky;
    for (int k = 0; k < NDIG; k++) begin
      if ((bpb_pkg::CFG_W+1)'(k) < keep) begin
        bcd_next[4*k +: 4] = digits_in[4*k +: 4];
      end else if (digits_in[4*k +: 4] != 4'd0) begin
        overflow_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    bcd_digits <= bcd_next;
    overflow   <= overflow_next;
  end

endmodule

// ----- rtl/binary_to_packed_bcd.sv -----
`timescale 1ns / 1ps
// Channel   Handshake         Payload
// input     start / busy      value[31:0]
// result    done (strobe)     bcd_digits[39:0], overflow
// config    cfg_we            cfg_data[2:0] -> digit_bytes
//
// One word enters per cycle; busy stays low.
// A word passes through a row of 32 registered shift-and-correct cells, one per
// input bit, and then through the masking output register.
// Reset clears the pipeline valid bits and sets digit_bytes to 5.
// The receiver cannot stall: done is high for one cycle per word.

module binary_to_packed_bcd #(
  parameter int MAX_BYTES = bpb_pkg::MAX_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [bpb_pkg::VALUE_W-1:0] value,
  output logic                        done,
  output logic [bpb_pkg::BCD_W-1:0]   bcd_digits,
  output logic                        overflow,
  input  logic                        cfg_we,
  input  logic [bpb_pkg::CFG_W-1:0]   cfg_data
);

  localparam int NDIG = 2 * MAX_BYTES;
  localparam int NCELL = bpb_pkg::VALUE_W;

  logic [bpb_pkg::CFG_W-1:0] digit_bytes;

  bpb_pkg::ctl_t               ctl   [NCELL+1];
  logic [bpb_pkg::VALUE_W-1:0] rest  [NCELL+1];
  logic [4*NDIG-1:0]           digs  [NCELL+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_bytes <= bpb_pkg::DIGIT_BYTES_RST;
    end else if (cfg_we) begin
      digit_bytes <= cfg_data;
    end
  end

  assign ctl[0].valid  = start & ~busy;
  assign ctl[0].sticky = 1'b0;
  assign ctl[0].bytes  = digit_bytes;
  assign rest[0]       = value;
  assign digs[0]       = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    bpb_cell #(
      .NDIG(NDIG)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl_in    (ctl[i]),
      .rest_in   (rest[i]),
      .digits_in (digs[i]),
      .ctl_out   (ctl[i+1]),
      .rest_out  (rest[i+1]),
      .digits_out(digs[i+1])
    );
  end

  bpb_out #(
    .MAX_BYTES(MAX_BYTES)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ctl[NCELL]),
    .digits_in (digs[NCELL]),
    .done      (done),
    .bcd_digits(bcd_digits),
    .overflow  (overflow)
  );

`ifndef SYNTH
  logic nib_bad;

  always_comb begin
    nib_bad = 1'b0;
    for (int k = 0; k < bpb_pkg::BCD_W / 4; k++) begin
      if (bcd_digits[4*k +: 4] > 4'd9) begin
        nib_bad = 1'b1;
      end
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(NCELL+1) done)
    else $error("word did not complete after pipeline latency");

  a_digits: assert property (@(posedge clk) disable iff (rst)
    done |-> !nib_bad)
    else $error("result nibble out of decimal range");

  a_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done strobe after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    ctl[NCELL].valid |-> $past(ctl[NCELL-1].valid))
    else $error("valid bit appeared in the cell chain");
`endif

endmodule

// ----- sim/binary_to_packed_bcd_test.sv -----
`timescale 1ns / 1ps

module binary_to_packed_bcd_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int WORDS_PER_PHASE = 135;

  typedef struct {
    logic [bpb_pkg::BCD_W-1:0] bcd;
    logic                      ovf;
  } bcd_word_t;

  class bcd_scoreboard;
    bcd_word_t                 expected_q[$];
    logic [bpb_pkg::CFG_W-1:0] digit_bytes;
    int                        errors;
    int                        words_in;
    int                        words_out;
    int                        overflows;
    bit [7:0]                  bytes_seen;

    function new();
      digit_bytes = bpb_pkg::DIGIT_BYTES_RST;
      errors = 0;
      words_in = 0;
      words_out = 0;
      overflows = 0;
      bytes_seen = '0;
    endfunction

    function void set_bytes(logic [bpb_pkg::CFG_W-1:0] b);
      digit_bytes = b;
    endfunction

    function bcd_word_t convert(logic [bpb_pkg::VALUE_W-1:0] v);
      bcd_word_t   w;
      int unsigned rest;
      int unsigned nb;
      rest = v;
      nb = (digit_bytes > bpb_pkg::MAX_BYTES_DEF) ? bpb_pkg::MAX_BYTES_DEF : digit_bytes;
      w.bcd = '0;
      for (int k = 0; k < 2 * nb; k++) begin
        w.bcd[4*k +: 4] = 4'(rest % 10);
        rest = rest / 10;
      end
      w.ovf = (rest != 0);
      return w;
    endfunction

    function void note_value(logic [bpb_pkg::VALUE_W-1:0] v);
      bcd_word_t w;
      w = convert(v);
      expected_q.push_back(w);
      words_in++;
      bytes_seen[digit_bytes] = 1'b1;
      if (w.ovf) overflows++;
    endfunction

    function void check_word(logic [bpb_pkg::BCD_W-1:0] bcd, logic ovf);
      bcd_word_t w;
      words_out++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word bcd_digits %h overflow %b", $time, bcd, ovf);
        errors++;
        return;
      end
      w = expected_q.pop_front();
      if (bcd !== w.bcd) begin
        $display("%0t: bcd_digits expected %h got %h", $time, w.bcd, bcd);
        errors++;
      end
      if (ovf !== w.ovf) begin
        $display("%0t: overflow expected %b got %b", $time, w.ovf, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [bpb_pkg::VALUE_W-1:0] value;
  logic                        done;
  logic [bpb_pkg::BCD_W-1:0]   bcd_digits;
  logic                        overflow;
  logic                        cfg_we;
  logic [bpb_pkg::CFG_W-1:0]   cfg_data;

  bcd_scoreboard sb = new();
  int            quiet_cycles = 0;

  binary_to_packed_bcd i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .done       (done),
    .bcd_digits (bcd_digits),
    .overflow   (overflow),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_word(bcd_digits, overflow);
      if (start && !busy) sb.note_value(value);
      if (cfg_we) sb.set_bytes(cfg_data);
      if (done || (start && !busy) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d words pending", $time, sb.pending());
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [bpb_pkg::VALUE_W-1:0] rand_value();
    int unsigned p;
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        p = 1;
        repeat ($urandom_range(9)) p = p * 10;
        return p + $urandom_range(2) - 1;
      end
      2: return $urandom >> $urandom_range(31);
      default: return $urandom_range(99999);
    endcase
  endfunction

  task automatic send_word(input logic [bpb_pkg::VALUE_W-1:0] v, input bit idle_on);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 24) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    value = v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start and hold until every word is back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [bpb_pkg::CFG_W-1:0] b);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = b;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_phase(input logic [bpb_pkg::CFG_W-1:0] b, input bit idle_on);
    write_cfg(b);
    repeat (WORDS_PER_PHASE) send_word(rand_value(), idle_on);
  endtask

  initial begin
    logic [bpb_pkg::VALUE_W-1:0] dir_q[$];
    logic [bpb_pkg::CFG_W-1:0]   phase_bytes[$];

    rst = 1'b1;
    start = 1'b0;
    value = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    dir_q = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999999999,
              32'd1000000000, 32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555};
    foreach (dir_q[i]) send_word(dir_q[i], 1'b1);
    write_cfg(3'd0);
    dir_q = '{32'd0, 32'd1};
    foreach (dir_q[i]) send_word(dir_q[i], 1'b1);
    write_cfg(3'd1);
    dir_q = '{32'd99, 32'd100};
    foreach (dir_q[i]) send_word(dir_q[i], 1'b1);
    write_cfg(3'd4);
    dir_q = '{32'd99999999, 32'd100000000};
    foreach (dir_q[i]) send_word(dir_q[i], 1'b1);
    write_cfg(3'd7);
    dir_q = '{32'hFFFFFFFF, 32'd1234567890};
    foreach (dir_q[i]) send_word(dir_q[i], 1'b1);
    write_cfg(3'd6);
    dir_q = '{32'hFFFFFFFF};
    foreach (dir_q[i]) send_word(dir_q[i], 1'b1);

    phase_bytes = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd2, 3'd5};
    foreach (phase_bytes[i]) run_phase(phase_bytes[i], i != 4);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, sb.pending());
      sb.errors++;
    end

    $display("converted %0d words (%0d returned, %0d with overflow)",
             sb.words_in, sb.words_out, sb.overflows);
    $display("byte counts exercised (bit per setting): %b", sb.bytes_seen);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
